FILE: hw/rtl/psd_pkg.sv
// Shared types, constants and register indexes for the three-axis spring-damper controller.
package psd_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int AXES        = 3;
  localparam int DT_WIDTH    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int SCALE_WIDTH = 20;
  localparam int NUM_WIDTH   = DATA_WIDTH + 1 + SCALE_WIDTH;
  localparam int ACC_WIDTH   = 2 * DATA_WIDTH + SCALE_WIDTH + 4;
  localparam int AXIS_WIDTH  = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int INDEX_WIDTH = 3;

  localparam logic [SCALE_WIDTH-1:0] VEL_SCALE = SCALE_WIDTH'(1000000);

  localparam logic [DATA_WIDTH-1:0] STIFFNESS_RESET = DATA_WIDTH'(3932160);
  localparam logic [DATA_WIDTH-1:0] DAMPING_RESET   = DATA_WIDTH'(655360);
  localparam logic [DATA_WIDTH-1:0] INTEGRAL_RESET  = DATA_WIDTH'(65536);
  localparam logic [DATA_WIDTH-1:0] CENTER_Z_RESET  = DATA_WIDTH'(7209);
  localparam logic [DATA_WIDTH-2:0] SUM_LIMIT_RESET = (DATA_WIDTH-1)'(65536);

  typedef enum logic [INDEX_WIDTH-1:0] {
    REG_STIFFNESS = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_INTEGRAL  = 3'd2,
    REG_CENTER_X  = 3'd3,
    REG_CENTER_Y  = 3'd4,
    REG_CENTER_Z  = 3'd5,
    REG_SUM_LIMIT = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_D = 2'd1,
    TERM_I = 2'd2
  } term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NUM_GO,
    ST_NUM_RUN,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_TERM_GO,
    ST_TERM_RUN,
    ST_AXIS_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] position_x;
    logic signed [DATA_WIDTH-1:0] position_y;
    logic signed [DATA_WIDTH-1:0] position_z;
    logic [DT_WIDTH-1:0]          elapsed_us;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] force_x;
    logic signed [DATA_WIDTH-1:0] force_y;
    logic signed [DATA_WIDTH-1:0] force_z;
  } out_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_cmd_t;

endpackage

FILE: hw/rtl/psd_mac.sv
// Bit-serial multiply-accumulate: one multiplier bit per cycle into a signed accumulator.
module psd_mac import psd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  mac_cmd_t                    cmd,
  input  logic [NUM_WIDTH-1:0]        op,
  input  logic [DATA_WIDTH-1:0]       mult,
  output logic                        busy,
  output logic signed [ACC_WIDTH-1:0] acc
);

  logic [ACC_WIDTH-1:0]  op_sh;
  logic [DATA_WIDTH-1:0] mult_sh;
  logic                  neg;
  logic [ACC_WIDTH-1:0]  addend;

  assign addend = neg ? (~op_sh + ACC_WIDTH'(1)) : op_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (busy && ((mult_sh >> 1) == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_sh   <= ACC_WIDTH'(op);
      mult_sh <= mult;
      neg     <= cmd.neg;
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mult_sh[0]) begin
        acc <= acc + signed'(addend);
      end
      op_sh   <= op_sh << 1;
      mult_sh <= mult_sh >> 1;
    end
  end

endmodule

FILE: hw/rtl/psd_div.sv
// Restoring divider: one quotient bit per cycle, wide dividend by narrow divisor.
module psd_div import psd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] num,
  input  logic [DT_WIDTH-1:0]  den,
  output logic                 busy,
  output logic [NUM_WIDTH-1:0] quo
);

  localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

  logic [DT_WIDTH-1:0]  rem;
  logic [DT_WIDTH-1:0]  den_r;
  logic [CNT_WIDTH-1:0] count;
  logic [DT_WIDTH:0]    trial;
  logic                 fits;

  assign trial = {rem, quo[NUM_WIDTH-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (count == CNT_WIDTH'(1))) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
      count <= CNT_WIDTH'(NUM_WIDTH);
    end else if (busy) begin
      rem   <= fits ? DT_WIDTH'(trial - {1'b0, den_r}) : trial[DT_WIDTH-1:0];
      quo   <= {quo[NUM_WIDTH-2:0], fits};
      count <= count - CNT_WIDTH'(1);
    end
  end

endmodule

FILE: hw/rtl/pid_spring_damper_3axis.sv
// Top level: three-axis PID spring-damper force law on Q16.16 samples.
//
// Input channel in_valid/in_ready/in_data carries one position sample per
// axis and the microseconds since the previous sample. Output channel
// out_valid/out_ready/out_data carries one force per axis for each sample.
// Registers are written through cfg_wen/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
//
// One sample is worked on at a time, axis after axis. Per axis the
// bit-serial multiplier forms the velocity numerator, the restoring
// divider divides it by the elapsed time, and the multiplier then runs the
// three gain terms, ending early for short gains. A new sample is taken
// only once the previous one is through; in_ready is high only between
// samples.
//
// Reset restores the default gains and centre, clears the stored positions
// and error sums and marks the first sample as unprimed (no damping term).
// A finished result waits in the output register; while the receiver
// stalls, the next sample is accepted and worked on, and its result is
// held back until the previous transfer completes.
module pid_spring_damper_3axis import psd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_wen,
  input  logic [INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]  cfg_data
);

  localparam int W    = DATA_WIDTH;
  localparam int SH_W = ACC_WIDTH - FRAC_BITS;
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'((longint'(1) <<< (W - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_MIN = -SAT_MAX - SH_W'(1);

  state_t state, state_next;

  logic [W-1:0]        stiffness;
  logic [W-1:0]        damping;
  logic [W-1:0]        integral;
  logic signed [W-1:0] center [AXES];
  logic [W-2:0]        sum_limit;
  logic signed [W-1:0] prev [AXES];
  logic signed [W-1:0] accum [AXES];
  logic                primed;
  in_t                 sample;
  logic [DT_WIDTH-1:0] dt;
  logic [AXIS_WIDTH-1:0] axis;
  term_t               term;
  logic signed [W-1:0] force_buf [AXES];

  logic signed [W-1:0] pos_arr [AXES];
  logic signed [W-1:0] pos_sel;
  logic signed [W:0]   err;
  logic [W:0]          err_mag;
  logic signed [W:0]   diff;
  logic [W:0]          diff_mag;
  logic signed [W+1:0] sum_raw;
  logic signed [W+1:0] lim_pos;
  logic signed [W+1:0] lim_neg;
  logic signed [W-1:0] sum_c;
  logic [W-1:0]        sum_mag;
  logic signed [SH_W-1:0] shifted;
  logic signed [W-1:0] force_sat;
  logic                last_axis;
  logic                out_free;

  mac_cmd_t               mac_cmd;
  logic [NUM_WIDTH-1:0]   mac_op;
  logic [W-1:0]           mac_mult;
  logic                   mac_busy;
  logic signed [ACC_WIDTH-1:0] mac_acc;
  logic                   div_start;
  logic                   div_busy;
  logic [NUM_WIDTH-1:0]   div_quo;

  assign pos_arr[0] = sample.position_x;
  assign pos_arr[1] = sample.position_y;
  assign pos_arr[2] = sample.position_z;

  assign pos_sel  = pos_arr[axis];
  assign err      = (W+1)'(center[axis]) - (W+1)'(pos_sel);
  assign err_mag  = err[W] ? (~err + (W+1)'(1)) : err;
  assign diff     = (W+1)'(pos_sel) - (W+1)'(prev[axis]);
  assign diff_mag = diff[W] ? (~diff + (W+1)'(1)) : diff;
  assign sum_raw  = (W+2)'(accum[axis]) + (W+2)'(err);
  assign lim_pos  = signed'((W+2)'(sum_limit));
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (sum_raw > lim_pos) begin
      sum_c = W'(lim_pos);
    end else if (sum_raw < lim_neg) begin
      sum_c = W'(lim_neg);
    end else begin
      sum_c = W'(sum_raw);
    end
  end

  assign sum_mag = sum_c[W-1] ? (~sum_c + W'(1)) : sum_c;
  assign shifted = SH_W'(mac_acc >>> FRAC_BITS);

  always_comb begin
    if (shifted > SAT_MAX) begin
      force_sat = W'(SAT_MAX);
    end else if (shifted < SAT_MIN) begin
      force_sat = W'(SAT_MIN);
    end else begin
      force_sat = W'(shifted);
    end
  end

  assign last_axis = (axis == AXIS_WIDTH'(AXES - 1));
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_NUM_GO;
      end
      ST_NUM_GO:  state_next = ST_NUM_RUN;
      ST_NUM_RUN: begin
        if (!mac_busy) state_next = ST_DIV_GO;
      end
      ST_DIV_GO:  state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (!div_busy) state_next = ST_TERM_GO;
      end
      ST_TERM_GO: state_next = ST_TERM_RUN;
      ST_TERM_RUN: begin
        if (!mac_busy) state_next = (term == TERM_I) ? ST_AXIS_END : ST_TERM_GO;
      end
      ST_AXIS_END: state_next = last_axis ? ST_DONE : ST_NUM_GO;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    div_start = (state == ST_DIV_GO);
    mac_cmd   = '0;
    mac_op    = '0;
    mac_mult  = '0;
    case (state)
      ST_NUM_GO: begin
        mac_cmd  = '{start: 1'b1, clear: 1'b1, neg: 1'b0};
        mac_op   = NUM_WIDTH'(diff_mag);
        mac_mult = W'(VEL_SCALE);
      end
      ST_TERM_GO: begin
        case (term)
          TERM_P: begin
            mac_cmd  = '{start: 1'b1, clear: 1'b1, neg: err[W]};
            mac_op   = NUM_WIDTH'(err_mag);
            mac_mult = stiffness;
          end
          TERM_D: begin
            mac_cmd  = '{start: 1'b1, clear: 1'b0, neg: !diff[W]};
            mac_op   = div_quo;
            mac_mult = primed ? damping : '0;
          end
          TERM_I: begin
            mac_cmd  = '{start: 1'b1, clear: 1'b0, neg: sum_c[W-1]};
            mac_op   = NUM_WIDTH'(sum_mag);
            mac_mult = integral;
          end
          default: begin
            mac_cmd = '0;
          end
        endcase
      end
      default: begin
        mac_cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFFNESS_RESET;
      damping   <= DAMPING_RESET;
      integral  <= INTEGRAL_RESET;
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= CENTER_Z_RESET;
      sum_limit <= SUM_LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_STIFFNESS: stiffness <= cfg_data;
        REG_DAMPING:   damping   <= cfg_data;
        REG_INTEGRAL:  integral  <= cfg_data;
        REG_CENTER_X:  center[0] <= cfg_data;
        REG_CENTER_Y:  center[1] <= cfg_data;
        REG_CENTER_Z:  center[2] <= cfg_data;
        REG_SUM_LIMIT: sum_limit <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      out_valid <= 1'b0;
      axis      <= '0;
      term      <= TERM_P;
      for (int a = 0; a < AXES; a++) begin
        prev[a]  <= '0;
        accum[a] <= '0;
      end
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sample <= in_data;
            dt     <= (in_data.elapsed_us == '0) ? DT_WIDTH'(1) : in_data.elapsed_us;
            axis   <= '0;
            term   <= TERM_P;
          end
        end
        ST_TERM_RUN: begin
          if (!mac_busy && term != TERM_I) term <= term_t'(term + 2'd1);
        end
        ST_AXIS_END: begin
          accum[axis]     <= sum_c;
          prev[axis]      <= pos_sel;
          force_buf[axis] <= force_sat;
          term            <= TERM_P;
          if (!last_axis) axis <= axis + AXIS_WIDTH'(1);
        end
        ST_DONE: begin
          if (out_free) begin
            out_data.force_x <= force_buf[0];
            out_data.force_y <= force_buf[1];
            out_data.force_z <= force_buf[2];
            primed           <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  psd_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .op   (mac_op),
    .mult (mac_mult),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  psd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mac_acc[NUM_WIDTH-1:0]),
    .den   (dt),
    .busy  (div_busy),
    .quo   (div_quo)
  );

endmodule

FILE: hw/rtl/psd_checker.sv
// Port-level checks on the spring-damper controller, bound to the top level.
module psd_checker import psd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("state after reset wrong");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised straight after input transfer");

endmodule

bind pid_spring_damper_3axis psd_checker u_psd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/tb.sv
// Self-checking testbench for the three-axis PID spring-damper controller.
module tb import psd_pkg::*; ();

  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_wen = 1'b0;
  reg_index_t cfg_index = REG_STIFFNESS;
  logic [DATA_WIDTH-1:0] cfg_data = '0;

  logic steady = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned forces_seen = 0;
  int unsigned settings_used = 0;

  logic [63:0] kp, kd, ki, limit;
  logic signed [63:0] centre[AXES];
  logic signed [63:0] last_pos[AXES];
  logic signed [63:0] err_sum[AXES];
  logic primed;
  out_t expected_forces[$];

  pid_spring_damper_3axis u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 8);
  end

  function automatic out_t predict_force(in_t s);
    logic signed [63:0] pos, err, sum, d, md;
    logic signed [127:0] acc, vel, sh;
    logic signed [DATA_WIDTH-1:0] f[AXES];
    logic [63:0] dt;
    out_t r;
    dt = (s.elapsed_us == 0) ? 64'd1 : 64'(s.elapsed_us);
    for (int a = 0; a < AXES; a++) begin
      case (a)
        0: pos = 64'(s.position_x);
        1: pos = 64'(s.position_y);
        default: pos = 64'(s.position_z);
      endcase
      err = centre[a] - pos;
      sum = err_sum[a] + err;
      if (sum > $signed(limit)) sum = $signed(limit);
      else if (sum < -$signed(limit)) sum = -$signed(limit);
      err_sum[a] = sum;
      acc = 128'(err) * $signed({64'd0, kp}) + 128'(sum) * $signed({64'd0, ki});
      if (primed) begin
        d = pos - last_pos[a];
        md = (d < 0) ? -d : d;
        vel = (128'(md) * 128'sd1000000) / $signed({64'd0, dt});
        if (d >= 0) acc = acc - vel * $signed({64'd0, kd});
        else acc = acc + vel * $signed({64'd0, kd});
      end
      last_pos[a] = pos;
      sh = acc >>> FRAC_BITS;
      if (sh > 128'sh7FFFFFFF) f[a] = 32'sh7FFFFFFF;
      else if (sh < -128'sh80000000) f[a] = 32'sh80000000;
      else f[a] = sh[DATA_WIDTH-1:0];
    end
    primed = 1'b1;
    r.force_x = f[0];
    r.force_y = f[1];
    r.force_z = f[2];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      forces_seen <= forces_seen + 1;
      if (expected_forces.size() == 0) begin
        $error("force transfer with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = expected_forces.pop_front();
        if (out_data.force_x !== want.force_x) begin
          $error("force_x expected %0d actual %0d", want.force_x, out_data.force_x);
          mismatches++;
        end
        if (out_data.force_y !== want.force_y) begin
          $error("force_y expected %0d actual %0d", want.force_y, out_data.force_y);
          mismatches++;
        end
        if (out_data.force_z !== want.force_z) begin
          $error("force_z expected %0d actual %0d", want.force_z, out_data.force_z);
          mismatches++;
        end
      end
    end
  end

  task automatic send_sample(input in_t s);
    if (!steady && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    expected_forces.push_back(predict_force(s));
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_WIDTH-1:0] v);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_STIFFNESS: kp = 64'(v);
      REG_DAMPING:   kd = 64'(v);
      REG_INTEGRAL:  ki = 64'(v);
      REG_CENTER_X:  centre[0] = 64'($signed(v));
      REG_CENTER_Y:  centre[1] = 64'($signed(v));
      REG_CENTER_Z:  centre[2] = 64'($signed(v));
      REG_SUM_LIMIT: limit = 64'(v[DATA_WIDTH-2:0]);
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      default: return 32'($signed($urandom_range(524287)) - 262144);
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'hFFFFFFFF : 32'd0;
      default: return $urandom_range(8388607);
    endcase
  endfunction

  function automatic in_t make_sample(int axis_bias);
    in_t s;
    s.position_x = 32'(centre[0]) + rand_word();
    s.position_y = 32'(centre[1]) + rand_word();
    s.position_z = 32'(centre[2]) + rand_word();
    if (axis_bias == 0) begin
      s.position_x = 32'(centre[0]) + 32'($signed($urandom_range(4095)) - 2048);
      s.position_y = 32'(centre[1]) + 32'($signed($urandom_range(4095)) - 2048);
      s.position_z = 32'(centre[2]) + 32'($signed($urandom_range(4095)) - 2048);
    end
    case ($urandom_range(9))
      0: s.elapsed_us = 16'd0;
      1: s.elapsed_us = 16'hFFFF;
      2: s.elapsed_us = 16'($urandom);
      default: s.elapsed_us = 16'($urandom_range(9000, 1));
    endcase
    return s;
  endfunction

  task automatic test_defaults();
    in_t s;
    s = '{position_x: 32'sd0, position_y: 32'sd0, position_z: 32'sd0, elapsed_us: 16'd0};
    send_sample(s);
    s = '{position_x: 32'sd1000, position_y: -32'sd1000, position_z: 32'sd7209,
          elapsed_us: 16'd0};
    send_sample(s);
    s = '{position_x: 32'sh7FFFFFFF, position_y: 32'sh80000000, position_z: 32'sd0,
          elapsed_us: 16'd1};
    send_sample(s);
    s = '{position_x: 32'sh80000000, position_y: 32'sh7FFFFFFF, position_z: -32'sd1,
          elapsed_us: 16'hFFFF};
    send_sample(s);
    for (int i = 0; i < 6; i++) send_sample(make_sample(0));
    settings_used++;
  endtask

  task automatic test_extreme_registers();
    in_t s;
    write_reg(REG_STIFFNESS, 32'hFFFFFFFF);
    write_reg(REG_DAMPING, 32'hFFFFFFFF);
    write_reg(REG_INTEGRAL, 32'hFFFFFFFF);
    write_reg(REG_CENTER_X, 32'h7FFFFFFF);
    write_reg(REG_CENTER_Y, 32'h80000000);
    write_reg(REG_CENTER_Z, 32'h00000000);
    write_reg(REG_SUM_LIMIT, 32'h7FFFFFFF);
    s = '{position_x: 32'sh80000000, position_y: 32'sh7FFFFFFF, position_z: 32'sd0,
          elapsed_us: 16'd1};
    send_sample(s);
    s = '{position_x: 32'sh7FFFFFFF, position_y: 32'sh80000000, position_z: 32'sd5,
          elapsed_us: 16'd0};
    send_sample(s);
    send_sample(s);
    write_reg(REG_STIFFNESS, 32'd0);
    write_reg(REG_DAMPING, 32'd0);
    write_reg(REG_INTEGRAL, 32'd0);
    write_reg(REG_SUM_LIMIT, 32'd0);
    for (int i = 0; i < 4; i++) send_sample(make_sample(1));
    write_reg(REG_INTEGRAL, 32'h00010000);
    for (int i = 0; i < 4; i++) send_sample(make_sample(1));
    settings_used += 3;
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(REG_STIFFNESS, rand_gain());
      write_reg(REG_DAMPING, rand_gain());
      write_reg(REG_INTEGRAL, rand_gain());
      write_reg(REG_CENTER_X, rand_word());
      write_reg(REG_CENTER_Y, rand_word());
      write_reg(REG_CENTER_Z, rand_word());
      case ($urandom_range(3))
        0: write_reg(REG_SUM_LIMIT, 32'h7FFFFFFF);
        1: write_reg(REG_SUM_LIMIT, 32'd0);
        default: write_reg(REG_SUM_LIMIT, $urandom_range(2000000));
      endcase
      steady <= (ph == 5);
      for (int i = 0; i < 122; i++) send_sample(make_sample($urandom_range(2)));
      settings_used++;
    end
    steady <= 1'b0;
  endtask

  initial begin
    for (int a = 0; a < AXES; a++) begin
      centre[a] = 0;
      last_pos[a] = 0;
      err_sum[a] = 0;
    end
    centre[2] = 64'(CENTER_Z_RESET);
    kp = 64'(STIFFNESS_RESET);
    kd = 64'(DAMPING_RESET);
    ki = 64'(INTEGRAL_RESET);
    limit = 64'(SUM_LIMIT_RESET);
    primed = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_extreme_registers();
    test_random_phases();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d samples and %0d force transfers over %0d register settings",
             samples_sent, forces_seen, settings_used);
    $display("including extreme gains, centres, sum limits and zero elapsed time");
    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/psd_pkg.sv
hw/rtl/psd_mac.sv
hw/rtl/psd_div.sv
hw/rtl/pid_spring_damper_3axis.sv
hw/rtl/psd_checker.sv
tb/tb.sv
